/* hw/rtl/io_request_queue_dispatcher_core_defines.svh */
// Assertion macros shared by the dispatcher checker.
`ifndef IO_REQUEST_QUEUE_DISPATCHER_CORE_DEFINES_SVH
`define IO_REQUEST_QUEUE_DISPATCHER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IQD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dispatcher port check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define IQD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dispatcher port check failed");

`endif

/* hw/rtl/iqd_pkg.sv */
// Types, constants and helpers of the request queue dispatcher.
`default_nettype none
package iqd_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam int CMD_DEPTH = 2;
	localparam int CMD_PTR_W = 1;
	localparam int CMD_CNT_W = 2;

	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 24;

	localparam int ID_LEN = 14;
	localparam int CNT_W = 4;

	typedef enum logic [1:0] {
		KIND_DEVICE = 2'd0,
		KIND_READ   = 2'd1,
		KIND_SET    = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_high;
		logic [7:0] data_low;
	} entry_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_high;
		logic [7:0] data_low;
		logic [7:0] port_a;
		logic [3:0] port_c;
		logic [3:0] port_e;
	} cmd_t;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
		if (idx == IDX_W'(QUEUE_DEPTH - 1))
			return '0;
		return idx + IDX_W'(1);
	endfunction

	function automatic logic [7:0] id_byte(input logic [CNT_W-1:0] i);
		logic [7:0] b;
		case (i)
			4'd0:    b = 8'h53;
			4'd1:    b = 8'h4F;
			4'd2:    b = 8'h33;
			4'd3:    b = 8'h37;
			4'd4:    b = 8'h31;
			4'd5:    b = 8'h35;
			4'd6:    b = 8'h2D;
			4'd7:    b = 8'h31;
			4'd8:    b = 8'h48;
			4'd9:    b = 8'h2E;
			4'd10:   b = 8'h31;
			4'd11:   b = 8'h31;
			4'd12:   b = 8'h30;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/iqd_front.sv */
// Front end: accepts beats, keeps the overwriting request ring, issues service commands.
`default_nettype none
module iqd_front (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [iqd_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  wire                               s_tuser,
	output logic                              cmd_valid,
	input  wire                               cmd_ready,
	output iqd_pkg::cmd_t                     cmd
);

	iqd_pkg::entry_t                  mem [iqd_pkg::QUEUE_DEPTH];
	logic [iqd_pkg::IDX_W-1:0]        head_q, tail_q;
	logic [iqd_pkg::IDX_W-1:0]        tail_nxt;
	logic                             pend_s1;
	iqd_pkg::entry_t                  rd_s1;
	logic [7:0]                       port_a_s1;
	logic [3:0]                       port_c_s1, port_e_s1;
	iqd_pkg::entry_t                  wr_entry;
	logic                             accept, push_acc, svc_acc;

	assign s_tready = !pend_s1 || cmd_ready;
	assign accept   = s_tvalid && s_tready;
	assign push_acc = accept && !s_tuser;
	assign svc_acc  = accept && s_tuser && (head_q != tail_q);
	assign tail_nxt = iqd_pkg::next_idx(tail_q);

	assign wr_entry.kind      = iqd_pkg::kind_t'(s_tdata[1:0]);
	assign wr_entry.data_high = s_tdata[9:2];
	assign wr_entry.data_low  = s_tdata[17:10];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (push_acc) begin
				tail_q <= tail_nxt;
				if (tail_nxt == head_q)
					head_q <= iqd_pkg::next_idx(head_q);
			end else if (svc_acc) begin
				head_q <= iqd_pkg::next_idx(head_q);
			end
			if (svc_acc)
				pend_s1 <= 1'b1;
			else if (cmd_ready)
				pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_acc)
			mem[tail_q] <= wr_entry;
		if (svc_acc) begin
			rd_s1     <= mem[head_q];
			port_a_s1 <= s_tdata[25:18];
			port_c_s1 <= s_tdata[29:26];
			port_e_s1 <= s_tdata[33:30];
		end
	end

	assign cmd_valid     = pend_s1;
	assign cmd.kind      = rd_s1.kind;
	assign cmd.data_high = rd_s1.data_high;
	assign cmd.data_low  = rd_s1.data_low;
	assign cmd.port_a    = port_a_s1;
	assign cmd.port_c    = port_c_s1;
	assign cmd.port_e    = port_e_s1;

endmodule
`default_nettype wire

/* hw/rtl/iqd_cmd_fifo.sv */
// Short command queue between front end and back end.
`default_nettype none
module iqd_cmd_fifo (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  iqd_pkg::cmd_t  in_cmd,
	output logic           out_valid,
	input  wire            out_ready,
	output iqd_pkg::cmd_t  out_cmd
);

	iqd_pkg::cmd_t                  slots [iqd_pkg::CMD_DEPTH];
	logic [iqd_pkg::CMD_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [iqd_pkg::CMD_CNT_W-1:0]  count_q;
	logic                           wr_en, rd_en;

	assign in_ready  = count_q != iqd_pkg::CMD_CNT_W'(iqd_pkg::CMD_DEPTH);
	assign out_valid = count_q != '0;
	assign wr_en     = in_valid && in_ready;
	assign rd_en     = out_valid && out_ready;
	assign out_cmd   = slots[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + iqd_pkg::CMD_PTR_W'(1);
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + iqd_pkg::CMD_PTR_W'(1);
			if (wr_en && !rd_en)
				count_q <= count_q + iqd_pkg::CMD_CNT_W'(1);
			else if (rd_en && !wr_en)
				count_q <= count_q - iqd_pkg::CMD_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			slots[wr_ptr_q] <= in_cmd;
	end

endmodule
`default_nettype wire

/* hw/rtl/iqd_back.sv */
// Back end: runs service commands, drives the output latches and the result register.
`default_nettype none
module iqd_back (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cmd_valid,
	output logic                              cmd_ready,
	input  iqd_pkg::cmd_t                     cmd,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [iqd_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                              m_tuser,
	output logic                              m_tlast
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                      state_q;
	iqd_pkg::cmd_t               cmd_q;
	logic [iqd_pkg::CNT_W-1:0]   cnt_q;
	logic [7:0]                  latch_b_q, latch_d_q;
	logic                        m_tvalid_q, m_tuser_q, m_tlast_q;
	logic [7:0]                  m_byte_q, m_b_q, m_d_q;
	logic                        out_free;
	logic                        beat_valid, beat_last, beat_set;
	logic [7:0]                  beat_byte, b_nxt, d_nxt;

	assign cmd_ready = state_q == ST_IDLE;
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		beat_valid = 1'b0;
		beat_last  = 1'b1;
		beat_set   = 1'b0;
		beat_byte  = 8'h00;
		case (cmd_q.kind)
			iqd_pkg::KIND_DEVICE: begin
				beat_valid = 1'b1;
				beat_byte  = iqd_pkg::id_byte(cnt_q);
				beat_last  = cnt_q == iqd_pkg::CNT_W'(iqd_pkg::ID_LEN - 1);
			end
			iqd_pkg::KIND_READ: begin
				beat_valid = 1'b1;
				beat_byte  = (cnt_q == '0) ? cmd_q.port_a : {cmd_q.port_e, cmd_q.port_c};
				beat_last  = cnt_q != '0;
			end
			iqd_pkg::KIND_SET: beat_set = 1'b1;
			default: ;
		endcase
		b_nxt = beat_set ? cmd_q.data_high : latch_b_q;
		d_nxt = beat_set ? cmd_q.data_low : latch_d_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			latch_b_q  <= 8'h00;
			latch_d_q  <= 8'h00;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_RUN && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (out_free) begin
						latch_b_q  <= b_nxt;
						latch_d_q  <= d_nxt;
						if (beat_last)
							state_q <= ST_IDLE;
						else
							cnt_q <= cnt_q + iqd_pkg::CNT_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid)
			cmd_q <= cmd;
		if (state_q == ST_RUN && out_free) begin
			m_tuser_q <= beat_valid;
			m_tlast_q <= beat_last;
			m_byte_q  <= beat_byte;
			m_b_q     <= b_nxt;
			m_d_q     <= d_nxt;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = {m_d_q, m_b_q, m_byte_q};

endmodule
`default_nettype wire

/* hw/rtl/io_request_queue_dispatcher_core.sv */
// Top level of the request queue dispatcher.
// Input channel s_*: one beat is either a push (tuser 0) that stores a request in an
// 8-entry ring, or a service step (tuser 1) that pops the oldest request. The ring keeps
// at most seven requests; a push into a full ring drops the oldest one.
// Output channel m_*: one beat per result. tuser marks a byte to transmit, tlast ends
// the results of one service step, tdata also carries both output latch values.
// A push gives no beat. A service step on an empty ring gives none.
// A service step is held in the front stage register before it enters the command queue;
// the back end then loads the command and gives its result beats: 14 beats for the
// identifier, 2 for an input read, 1 for set-outputs or no-action.
// The back end takes no new service step until it has given all result beats of the last.
// Pushes run at one per cycle and continue while the back end works, until the two-entry
// command queue and the front stage fill up with pending service steps.
// When the receiver holds m_tready low, the current beat holds and the back end stops;
// backpressure reaches s_tready only through the command queue.
// Reset clears the ring pointers, both latches and all valid flags; ring contents stay
// undefined until written.
`default_nettype none
module io_request_queue_dispatcher_core (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// request_kind[1:0], data_high[9:2], data_low[17:10], port_a_pins[25:18],
	// port_c_nibble[29:26], port_e_nibble[33:30], zero[39:34]
	input  wire  [iqd_pkg::IN_TDATA_W-1:0]    s_tdata,
	// operation[0]
	input  wire                               s_tuser,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// tx_byte[7:0], latch_b_value[15:8], latch_d_value[23:16]
	output logic [iqd_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// byte_valid[0]
	output logic                              m_tuser,
	output logic                              m_tlast
);

	logic           f_valid, f_ready;
	iqd_pkg::cmd_t  f_cmd;
	logic           b_valid, b_ready;
	iqd_pkg::cmd_t  b_cmd;

	iqd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	iqd_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_cmd    (f_cmd),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_cmd   (b_cmd)
	);

	iqd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd       (b_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

/* hw/rtl/iqd_checker.sv */
// Port checker for the request queue dispatcher and its bind.
`default_nettype none
`include "io_request_queue_dispatcher_core_defines.svh"
module iqd_checker (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               s_tvalid,
	input wire                               s_tready,
	input wire [iqd_pkg::IN_TDATA_W-1:0]     s_tdata,
	input wire                               s_tuser,
	input wire                               m_tvalid,
	input wire                               m_tready,
	input wire [iqd_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input wire                               m_tuser,
	input wire                               m_tlast
);

	// Hold a stalled result beat.
	`IQD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	// A beat without a byte closes its run and carries a zero byte.
	`IQD_ASSERT_NOW(a_nobyte_last, m_tvalid && !m_tuser, m_tlast && (m_tdata[7:0] == 8'h00))

	// Within a run, the next beat is a byte beat and the latches stay put.
	`IQD_ASSERT_NEXT(a_run_latch, m_tvalid && m_tready && m_tuser && !m_tlast, !m_tvalid || (m_tuser && (m_tdata[23:8] == $past(m_tdata[23:8]))))

endmodule

bind io_request_queue_dispatcher_core iqd_checker u_iqd_checker (.*);
`default_nettype wire

/* tb/io_request_queue_dispatcher_core_tb.sv */
// Testbench for the request queue dispatcher: random push/service beats checked against a ring model.
`default_nettype none
module io_request_queue_dispatcher_core_tb;
	import iqd_pkg::*;

	localparam bit OP_PUSH = 1'b0;
	localparam bit OP_SERVICE = 1'b1;
	localparam int RANDOM_ITEMS = 230;
	localparam int IDLE_PCT = 28;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct {
		bit         op;
		kind_t      kind;
		logic [7:0] data_high;
		logic [7:0] data_low;
		logic [7:0] port_a;
		logic [3:0] port_c;
		logic [3:0] port_e;
	} request_t;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] tx_byte;
		logic       last_of_run;
		logic [7:0] latch_b;
		logic [7:0] latch_d;
	} tx_beat_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	io_request_queue_dispatcher_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	localparam logic [7:0] ID_STRING [ID_LEN] = '{
		8'h53, 8'h4F, 8'h33, 8'h37, 8'h31, 8'h35, 8'h2D,
		8'h31, 8'h48, 8'h2E, 8'h31, 8'h31, 8'h30, 8'h00
	};

	request_t   pending_reqs[$];
	request_t   cur_req;
	tx_beat_t   expected_beats[$];
	entry_t     ring_model[QUEUE_DEPTH];
	int         ring_head = 0;
	int         ring_tail = 0;
	logic [7:0] latch_b_model = 8'h00;
	logic [7:0] latch_d_model = 8'h00;
	int         accept_cnt = 0;
	int         err_cnt = 0;
	int         cycle_cnt = 0;
	logic       calm;

	// no idling on either side through the middle of the run
	assign calm = (accept_cnt >= 110) && (accept_cnt < 170);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	task automatic add_req(input bit op, input kind_t kind, input logic [7:0] dh,
			input logic [7:0] dl, input logic [7:0] pa, input logic [3:0] pc,
			input logic [3:0] pe);
		request_t r;
		r.op = op;
		r.kind = kind;
		r.data_high = dh;
		r.data_low = dl;
		r.port_a = pa;
		r.port_c = pc;
		r.port_e = pe;
		pending_reqs.push_back(r);
	endtask

	task automatic add_random_req(input bit op);
		add_req(op, kind_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
			8'($urandom), 4'($urandom), 4'($urandom));
	endtask

	task automatic queue_beat(input logic valid, input logic [7:0] tx, input logic last);
		tx_beat_t b;
		b.byte_valid = valid;
		b.tx_byte = tx;
		b.last_of_run = last;
		b.latch_b = latch_b_model;
		b.latch_d = latch_d_model;
		expected_beats.push_back(b);
	endtask

	task automatic dispatch_request(input request_t r);
		entry_t e;
		if (r.op == OP_PUSH) begin
			e.kind = r.kind;
			e.data_high = r.data_high;
			e.data_low = r.data_low;
			ring_model[ring_tail] = e;
			ring_tail = (ring_tail + 1) % QUEUE_DEPTH;
			// full ring: drop oldest
			if (ring_tail == ring_head)
				ring_head = (ring_head + 1) % QUEUE_DEPTH;
		end else if (ring_head != ring_tail) begin
			e = ring_model[ring_head];
			ring_head = (ring_head + 1) % QUEUE_DEPTH;
			case (e.kind)
				KIND_DEVICE: begin
					for (int k = 0; k < ID_LEN; k++)
						queue_beat(1'b1, ID_STRING[k], k == ID_LEN - 1);
				end
				KIND_READ: begin
					queue_beat(1'b1, r.port_a, 1'b0);
					queue_beat(1'b1, {r.port_e, r.port_c}, 1'b1);
				end
				KIND_SET: begin
					latch_b_model = e.data_high;
					latch_d_model = e.data_low;
					queue_beat(1'b0, 8'h00, 1'b1);
				end
				default: queue_beat(1'b0, 8'h00, 1'b1);
			endcase
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				dispatch_request(cur_req);
				accept_cnt <= accept_cnt + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					cur_req = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cur_req.op;
					s_tdata <= {6'b0, cur_req.port_e, cur_req.port_c, cur_req.port_a,
						cur_req.data_low, cur_req.data_high, cur_req.kind};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		tx_beat_t got;
		tx_beat_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.byte_valid = m_tuser;
				got.tx_byte = m_tdata[7:0];
				got.last_of_run = m_tlast;
				got.latch_b = m_tdata[15:8];
				got.latch_d = m_tdata[23:16];
				if (expected_beats.size() == 0) begin
					if (err_cnt < MAX_REPORTS)
						$display("unexpected beat: valid %0b byte %02h last %0b b %02h d %02h",
							got.byte_valid, got.tx_byte, got.last_of_run, got.latch_b,
							got.latch_d);
					err_cnt <= err_cnt + 1;
				end else begin
					want = expected_beats.pop_front();
					if (got !== want) begin
						if (err_cnt < MAX_REPORTS)
							$display("mismatch: exp %0b %02h %0b %02h %02h, got %0b %02h %0b %02h %02h",
								want.byte_valid, want.tx_byte, want.last_of_run, want.latch_b,
								want.latch_d, got.byte_valid, got.tx_byte, got.last_of_run,
								got.latch_b, got.latch_d);
						err_cnt <= err_cnt + 1;
					end
				end
			end
			m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int n_items;
		int n;
		// service on an empty ring
		add_random_req(OP_SERVICE);
		add_req(OP_PUSH, KIND_DEVICE, 8'h00, 8'hFF, 8'h00, 4'h0, 4'h0);
		add_req(OP_PUSH, KIND_READ, 8'hFF, 8'h00, 8'h00, 4'h0, 4'h0);
		add_req(OP_PUSH, KIND_SET, 8'hFF, 8'h00, 8'h00, 4'h0, 4'h0);
		add_req(OP_PUSH, KIND_NONE, 8'hA5, 8'h5A, 8'hFF, 4'hF, 4'hF);
		add_req(OP_SERVICE, KIND_DEVICE, 8'h00, 8'h00, 8'h12, 4'h3, 4'h4);
		add_req(OP_SERVICE, KIND_NONE, 8'hFF, 8'hFF, 8'hFF, 4'hF, 4'h0);
		add_req(OP_SERVICE, KIND_READ, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0);
		add_req(OP_SERVICE, KIND_SET, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0);
		// overflow: eight pushes, first one lost, then drain past empty
		add_req(OP_PUSH, KIND_SET, 8'h11, 8'h22, 8'h00, 4'h0, 4'h0);
		add_req(OP_PUSH, KIND_READ, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0);
		add_req(OP_PUSH, KIND_SET, 8'h00, 8'hFF, 8'h00, 4'h0, 4'h0);
		add_req(OP_PUSH, KIND_NONE, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0);
		add_req(OP_PUSH, KIND_READ, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0);
		add_req(OP_PUSH, KIND_DEVICE, 8'hFF, 8'hFF, 8'h00, 4'h0, 4'h0);
		add_req(OP_PUSH, KIND_SET, 8'h80, 8'h01, 8'h00, 4'h0, 4'h0);
		add_req(OP_PUSH, KIND_READ, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0);
		add_req(OP_SERVICE, KIND_NONE, 8'h00, 8'h00, 8'h00, 4'h0, 4'hF);
		add_req(OP_SERVICE, KIND_NONE, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0);
		add_req(OP_SERVICE, KIND_NONE, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0);
		add_req(OP_SERVICE, KIND_NONE, 8'h00, 8'h00, 8'hAA, 4'h5, 4'hA);
		add_req(OP_SERVICE, KIND_NONE, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0);
		add_req(OP_SERVICE, KIND_NONE, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0);
		add_req(OP_SERVICE, KIND_NONE, 8'h00, 8'h00, 8'h55, 4'hA, 4'h5);
		add_req(OP_SERVICE, KIND_NONE, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0);

		n_items = 0;
		while (n_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 80) begin
				// burst of pushes then matching services, sometimes overflowing
				n = $urandom_range(1, 10);
				for (int i = 0; i < n; i++)
					add_random_req(OP_PUSH);
				if ($urandom_range(0, 3) == 0)
					n++;
				for (int i = 0; i < n; i++)
					add_random_req(OP_SERVICE);
				n_items += 2 * n;
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					add_random_req(1'($urandom));
				n_items += n;
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || s_tvalid || expected_beats.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (err_cnt == 0 && expected_beats.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
